@@ rtl/core/mbc_pkg.sv @@
// ----------------------------------------------------------------------------
// mbc_pkg - shared types, constants and helpers of the escape colorizer
// Fixed-point widths, register indexes, colour weights, saturation helpers.
// ----------------------------------------------------------------------------
package mbc_pkg;

  localparam int COORD_BITS = 12;
  localparam int ITER_BITS  = 16;
  localparam int FRAC_BITS  = 28;
  localparam int Q_BITS     = FRAC_BITS + 4;    // signed Q4.F word
  localparam int STEP_BITS  = 31;
  localparam int CFG_BITS   = 32;
  localparam int CFG_IDX_BITS = 3;

  localparam int MUL_W   = 32;                  // shared multiplier operand
  localparam int PROD_W  = 2 * MUL_W;
  localparam int MAG_W   = PROD_W - FRAC_BITS;  // truncated product magnitude
  localparam int SUM_W   = 46;                  // headroom for c and z updates
  localparam int CPROD_W = COORD_BITS + STEP_BITS;
  localparam int K_BITS  = 12;
  localparam int KPROD_W = K_BITS + MUL_W;
  localparam int NUM_W   = KPROD_W + MUL_W;
  localparam int DEN_W   = PROD_W;
  localparam int CH_BITS = 8;
  localparam int DSH_W   = DEN_W + CH_BITS - 1;

  localparam logic [K_BITS-1:0] K_RED = K_BITS'(15 * 255);
  localparam logic [K_BITS-1:0] K_GB  = K_BITS'(9 * 255);

  localparam logic [MAG_W:0] ESC_LIMIT = (MAG_W + 1)'(4) << FRAC_BITS;

  localparam logic signed [CFG_BITS-1:0] START_RESET = -32'sd536870912;
  localparam logic [STEP_BITS-1:0]       STEP_RESET  = STEP_BITS'(1048576);
  localparam logic [ITER_BITS-1:0]       LIMIT_RESET = ITER_BITS'(100);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_START_REAL,
    REG_START_IMAG,
    REG_STEP_REAL,
    REG_STEP_IMAG,
    REG_ITER_LIMIT
  } cfg_reg_t;

  // Clamp a wide signed sum into the Q4.F range.
  function automatic logic signed [Q_BITS-1:0] sat_q(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-Q_BITS:0] upper;
    upper = v[SUM_W-1:Q_BITS-1];
    if ((&upper) || (~|upper)) begin
      return v[Q_BITS-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(Q_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(Q_BITS-1){1'b1}}};
    end
  endfunction

  // Magnitude of a Q4.F value; the most negative value maps to 2^(Q_BITS-1).
  function automatic logic [MUL_W-1:0] abs_q(input logic signed [Q_BITS-1:0] v);
    logic [Q_BITS-1:0] neg;
    neg = $unsigned(-v);
    return v[Q_BITS-1] ? MUL_W'(neg) : MUL_W'($unsigned(v));
  endfunction

endpackage

@@ rtl/core/mbc_mul.sv @@
// ----------------------------------------------------------------------------
// mbc_mul - shared unsigned multiplier
// One full-width unsigned product per cycle, registered at the output.
// ----------------------------------------------------------------------------
module mbc_mul
  import mbc_pkg::*;
(
  input  logic              clk,
  input  logic [MUL_W-1:0]  a,
  input  logic [MUL_W-1:0]  b,
  output logic [PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

@@ rtl/core/mandelbrot_escape_colorizer.sv @@
// ----------------------------------------------------------------------------
// mandelbrot_escape_colorizer - escape-time pixel evaluator with colouring
// Forms c from a pixel index, iterates z = z*z + c and colours the result.
// ----------------------------------------------------------------------------
// Usage:
//   Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the start
//   point, per-pixel step and iteration limit; cfg_ready is always high.
//   Write it only while no pixel is in flight.
//   Pixel channel (pixel_valid/pixel_ready) takes one request: a column and a
//   row. pixel_ready is high only while the sequencer is idle.
//   Result channel (result_valid/result_ready) returns the echoed indexes, the
//   iteration count, the inside flag and a 24-bit RGB colour.
// Datapath and sequencing:
//   All products go through one registered 32x32 multiplier. Forming c scales
//   the column and row by their steps, each iteration runs x*x, y*y, x*y,
//   then the escape test and update, and colouring an escaped pixel uses five
//   shared products, then per channel three products and an 8-step restoring
//   divide. The block takes one request at a time.
// Reset and stall:
//   rst reloads the configuration defaults and drops any request in flight.
//   A finished result waits in the output register; the next request is
//   accepted meanwhile, and its result holds in the sequencer until taken.
// ----------------------------------------------------------------------------
module mandelbrot_escape_colorizer
  import mbc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  // configuration writes
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data,
  // pixel requests
  input  logic                    pixel_valid,
  output logic                    pixel_ready,
  input  logic [COORD_BITS-1:0]   column_index,
  input  logic [COORD_BITS-1:0]   row_index,
  // results
  output logic                    result_valid,
  input  logic                    result_ready,
  output logic [COORD_BITS-1:0]   out_column,
  output logic [COORD_BITS-1:0]   out_row,
  output logic [ITER_BITS-1:0]    iteration_count,
  output logic                    inside_set,
  output logic [3*CH_BITS-1:0]    pixel_color
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_C_RE,
    S_C_IM,
    S_C_FIN,
    S_SQ_X,
    S_SQ_Y,
    S_MUL_XY,
    S_UPD,
    S_CL_MN,
    S_CL_MM,
    S_CL_NN,
    S_CL_LL,
    S_CL_DEN,
    S_CH_V,
    S_CH_KLO,
    S_CH_KHI,
    S_CH_FORM,
    S_CH_DIV,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    CH_RED,
    CH_GREEN,
    CH_BLUE
  } chan_t;

  // configuration
  logic signed [Q_BITS-1:0] start_real;
  logic signed [Q_BITS-1:0] start_imag;
  logic [STEP_BITS-1:0]     step_real;
  logic [STEP_BITS-1:0]     step_imag;
  logic [ITER_BITS-1:0]     iteration_limit;

  // sequencer and datapath registers
  state_t                   state;
  logic [COORD_BITS-1:0]    col;
  logic [COORD_BITS-1:0]    row;
  logic signed [Q_BITS-1:0] cr;
  logic signed [Q_BITS-1:0] ci;
  logic signed [Q_BITS-1:0] x;
  logic signed [Q_BITS-1:0] y;
  logic [ITER_BITS-1:0]     n;
  logic [MAG_W-1:0]         x2;
  logic [MAG_W-1:0]         y2;
  logic                     in_set;
  logic [MUL_W-1:0]         mn;
  logic [MUL_W-1:0]         mm;
  logic [MUL_W-1:0]         nn;
  logic [PROD_W-1:0]        v;
  logic [KPROD_W-1:0]       klo;
  logic [DEN_W-1:0]         den;
  logic [NUM_W-1:0]         rem;
  logic [DSH_W-1:0]         dsh;
  logic [CH_BITS-1:0]       q;
  logic [2:0]               bitc;
  chan_t                    chan;
  logic [CH_BITS-1:0]       red;
  logic [CH_BITS-1:0]       grn;
  logic [CH_BITS-1:0]       blu;

  // shared multiplier
  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [PROD_W-1:0] prod;

  // combinational helpers
  logic [ITER_BITS-1:0]     m_val;
  logic [MUL_W-1:0]         k_sel;
  logic [MAG_W-1:0]         prod_q;
  logic signed [SUM_W-1:0]  xy_s;
  logic signed [SUM_W-1:0]  xn_sum;
  logic signed [SUM_W-1:0]  yn_sum;
  logic signed [SUM_W-1:0]  cr_sum;
  logic signed [SUM_W-1:0]  ci_sum;
  logic                     escaped;
  logic                     div_ge;
  logic [NUM_W-1:0]         dsh_ext;
  logic [CH_BITS-1:0]       q_next;

  assign cfg_ready   = 1'b1;
  assign pixel_ready = (state == S_IDLE);

  assign m_val  = iteration_limit - n;
  assign k_sel  = (chan == CH_RED) ? MUL_W'(K_RED) : MUL_W'(K_GB);

  // Truncated magnitude of a Q4.F product; sign is applied separately.
  assign prod_q = prod[PROD_W-1:FRAC_BITS];
  assign xy_s   = (x[Q_BITS-1] ^ y[Q_BITS-1]) ? -$signed(SUM_W'(prod_q))
                                               : $signed(SUM_W'(prod_q));

  assign escaped = ({1'b0, x2} + {1'b0, y2}) > ESC_LIMIT;
  assign xn_sum  = $signed(SUM_W'(x2)) - $signed(SUM_W'(y2)) + SUM_W'(cr);
  assign yn_sum  = (xy_s <<< 1) + SUM_W'(ci);

  // Start point plus index times step; the product is always non-negative.
  assign cr_sum = SUM_W'(start_real) + $signed(SUM_W'(prod[CPROD_W-1:0]));
  assign ci_sum = SUM_W'(start_imag) + $signed(SUM_W'(prod[CPROD_W-1:0]));

  assign dsh_ext = NUM_W'(dsh);
  assign div_ge  = (rem >= dsh_ext);
  assign q_next  = {q[CH_BITS-2:0], div_ge};

  // Steer the shared multiplier by sequencer step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_C_RE: begin
        mul_a = MUL_W'(col);
        mul_b = MUL_W'(step_real);
      end
      S_C_IM: begin
        mul_a = MUL_W'(row);
        mul_b = MUL_W'(step_imag);
      end
      S_SQ_X: begin
        mul_a = abs_q(x);
        mul_b = abs_q(x);
      end
      S_SQ_Y: begin
        mul_a = abs_q(y);
        mul_b = abs_q(y);
      end
      S_MUL_XY: begin
        mul_a = abs_q(x);
        mul_b = abs_q(y);
      end
      S_CL_MN: begin
        mul_a = MUL_W'(m_val);
        mul_b = MUL_W'(n);
      end
      S_CL_MM: begin
        mul_a = MUL_W'(m_val);
        mul_b = MUL_W'(m_val);
      end
      S_CL_NN: begin
        mul_a = MUL_W'(n);
        mul_b = MUL_W'(n);
      end
      S_CL_LL: begin
        mul_a = MUL_W'(iteration_limit);
        mul_b = MUL_W'(iteration_limit);
      end
      S_CL_DEN: begin
        // square the limit squared straight from the product register
        mul_a = prod[MUL_W-1:0];
        mul_b = prod[MUL_W-1:0];
      end
      S_CH_V: begin
        case (chan)
          CH_RED: begin
            mul_a = mn;
            mul_b = mn;
          end
          CH_GREEN: begin
            mul_a = mm;
            mul_b = mn;
          end
          default: begin
            mul_a = mn;
            mul_b = nn;
          end
        endcase
      end
      S_CH_KLO: begin
        mul_a = k_sel;
        mul_b = prod[MUL_W-1:0];
      end
      S_CH_KHI: begin
        mul_a = k_sel;
        mul_b = v[PROD_W-1:MUL_W];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  mbc_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      result_valid    <= 1'b0;
      start_real      <= START_RESET;
      start_imag      <= START_RESET;
      step_real       <= STEP_RESET;
      step_imag       <= STEP_RESET;
      iteration_limit <= LIMIT_RESET;
      chan            <= CH_RED;
      bitc            <= '0;
      n               <= '0;
    end else begin
      // Configuration writes; unknown indexes are dropped.
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_START_REAL: start_real      <= cfg_data;
          REG_START_IMAG: start_imag      <= cfg_data;
          REG_STEP_REAL:  step_real       <= cfg_data[STEP_BITS-1:0];
          REG_STEP_IMAG:  step_imag       <= cfg_data[STEP_BITS-1:0];
          REG_ITER_LIMIT: iteration_limit <= cfg_data[ITER_BITS-1:0];
          default: ;
        endcase
      end

      // Drop the output once taken; a new load below overrides this.
      if (result_ready) begin
        result_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (pixel_valid) begin
            col   <= column_index;
            row   <= row_index;
            state <= S_C_RE;
          end
        end
        S_C_RE: begin
          state <= S_C_IM;
        end
        S_C_IM: begin
          cr    <= sat_q(cr_sum);
          state <= S_C_FIN;
        end
        S_C_FIN: begin
          ci    <= sat_q(ci_sum);
          x     <= '0;
          y     <= '0;
          n     <= '0;
          state <= S_SQ_X;
        end
        S_SQ_X: begin
          // limit reached: the point counts as inside
          if (n >= iteration_limit) begin
            in_set <= 1'b1;
            state  <= S_DONE;
          end else begin
            state  <= S_SQ_Y;
          end
        end
        S_SQ_Y: begin
          x2    <= prod_q;
          state <= S_MUL_XY;
        end
        S_MUL_XY: begin
          y2    <= prod_q;
          state <= S_UPD;
        end
        S_UPD: begin
          if (escaped) begin
            in_set <= 1'b0;
            state  <= S_CL_MN;
          end else begin
            x     <= sat_q(xn_sum);
            y     <= sat_q(yn_sum);
            n     <= n + 1'b1;
            state <= S_SQ_X;
          end
        end
        S_CL_MN: begin
          chan  <= CH_RED;
          state <= S_CL_MM;
        end
        S_CL_MM: begin
          mn    <= prod[MUL_W-1:0];
          state <= S_CL_NN;
        end
        S_CL_NN: begin
          mm    <= prod[MUL_W-1:0];
          state <= S_CL_LL;
        end
        S_CL_LL: begin
          nn    <= prod[MUL_W-1:0];
          state <= S_CL_DEN;
        end
        S_CL_DEN: begin
          state <= S_CH_V;
        end
        S_CH_V: begin
          // the limit to the fourth arrives only on the first channel
          if (chan == CH_RED) begin
            den <= prod;
          end
          state <= S_CH_KLO;
        end
        S_CH_KLO: begin
          v     <= prod;
          state <= S_CH_KHI;
        end
        S_CH_KHI: begin
          klo   <= prod[KPROD_W-1:0];
          state <= S_CH_FORM;
        end
        S_CH_FORM: begin
          rem   <= {prod[KPROD_W-1:0], {MUL_W{1'b0}}} + NUM_W'(klo);
          dsh   <= {den, {(CH_BITS-1){1'b0}}};
          q     <= '0;
          bitc  <= 3'(CH_BITS - 1);
          state <= S_CH_DIV;
        end
        S_CH_DIV: begin
          // restoring divide, one quotient bit a cycle, MSB first
          if (div_ge) begin
            rem <= rem - dsh_ext;
          end
          q   <= q_next;
          dsh <= dsh >> 1;
          if (bitc == '0) begin
            case (chan)
              CH_RED: begin
                red   <= q_next;
                chan  <= CH_GREEN;
                state <= S_CH_V;
              end
              CH_GREEN: begin
                grn   <= q_next;
                chan  <= CH_BLUE;
                state <= S_CH_V;
              end
              default: begin
                blu   <= q_next;
                state <= S_DONE;
              end
            endcase
          end else begin
            bitc <= bitc - 1'b1;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (!result_valid || result_ready) begin
            out_column      <= col;
            out_row         <= row;
            iteration_count <= n;
            inside_set      <= in_set;
            pixel_color     <= in_set ? '0 : {red, grn, blu};
            result_valid    <= 1'b1;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/mbc_checker.sv @@
// ----------------------------------------------------------------------------
// mbc_checker - port-level checks for the escape colorizer
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
module mbc_checker
  import mbc_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  pixel_valid,
  input logic                  pixel_ready,
  input logic                  result_valid,
  input logic                  result_ready,
  input logic [COORD_BITS-1:0] out_column,
  input logic [COORD_BITS-1:0] out_row,
  input logic [ITER_BITS-1:0]  iteration_count,
  input logic                  inside_set,
  input logic [3*CH_BITS-1:0]  pixel_color
);

  // a request keeps the block busy on the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_ready |=> !pixel_ready)
    else $error("pixel_ready high right after a request was accepted");

  // a new result only appears while the sequencer is busy
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(!pixel_ready))
    else $error("result raised while the block was idle");

  // points inside the set are black
  a_inside_black: assert property (@(posedge clk) disable iff (rst)
    result_valid && inside_set |-> pixel_color == '0)
    else $error("inside point with nonzero colour");

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(pixel_color) &&
      $stable(iteration_count) && $stable(inside_set) &&
      $stable(out_column) && $stable(out_row))
    else $error("stalled result changed");

endmodule

bind mandelbrot_escape_colorizer mbc_checker u_mbc_checker (.*);
